/* src/positional_array_list_assert.svh */
// Assertion macros shared by the list controller and datapath.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pal_pkg.sv */
// Shared types and codes for the positional array list.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package pal_pkg;

  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int LEN_W = 8;

  typedef enum logic [1:0] {
    ACT_GET    = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    action_t                   action;
    logic [POS_W-1:0]          position;
    logic signed [VAL_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VAL_W-1:0]   read_value;
    logic [LEN_W-1:0]          current_length;
    logic                      is_empty;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_req;    // capture the accepted request
    logic decode;    // latch status, clear read value, set shift index
    logic rd_p0;     // read the addressed entry
    logic rd_prev;   // read the entry below the shift index
    logic rd_cur;    // read the entry at the shift index
    logic cap_rd;    // capture read data as the result value
    logic shift_up;  // write read data at the shift index, step down
    logic shift_dn;  // write read data below the shift index, step up
    logic put_val;   // write the new value and grow the list
    logic dec_cnt;   // shrink the list
    logic ld_out;    // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_t action;
    logic    err;
    logic    ins_more;
    logic    del_more;
    logic    out_busy;
  } stat_t;

endpackage

`default_nettype wire

/* src/pal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/pal_ctrl.sv */
// Sequencing state machine for the positional array list.
// Depends on pal_pkg and positional_array_list_assert.svh.
`default_nettype none

module pal_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pal_pkg::stat_t st,
  output pal_pkg::cmd_t      cmd
);

  import pal_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_GET_WAIT = 9'b000000100,
    S_INS_CHK  = 9'b000001000,
    S_INS_WR   = 9'b000010000,
    S_DEL_WAIT = 9'b000100000,
    S_DEL_CHK  = 9'b001000000,
    S_DEL_WR   = 9'b010000000,
    S_FIN      = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take a new beat only when idle
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (st.err) begin
          state_nxt = S_FIN;
        end else begin
          case (st.action)
            ACT_GET: begin
              cmd.rd_p0 = 1'b1;
              state_nxt = S_GET_WAIT;
            end
            ACT_INSERT: begin
              state_nxt = S_INS_CHK;
            end
            ACT_DELETE: begin
              cmd.rd_p0 = 1'b1;
              state_nxt = S_DEL_WAIT;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_GET_WAIT: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_FIN;
      end
      S_INS_CHK: begin
        if (st.ins_more) begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_WR;
        end else begin
          cmd.put_val = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_INS_WR: begin
        cmd.shift_up = 1'b1;
        state_nxt    = S_INS_CHK;
      end
      S_DEL_WAIT: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (st.del_more) begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_DEL_WR;
        end else begin
          cmd.dec_cnt = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_DEL_WR: begin
        cmd.shift_dn = 1'b1;
        state_nxt    = S_DEL_CHK;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "positional_array_list_assert.svh"

  `PAL_ASSERT(a_accept_decode, (in_valid && !in_stall) |=> (state_r == S_DECODE), "accepted beat not decoded")
  `PAL_ASSERT(a_ins_wr_after_rd, (state_r == S_INS_WR) |-> $past(cmd.rd_prev), "shift write without read")
  `PAL_ASSERT(a_del_wr_after_rd, (state_r == S_DEL_WR) |-> $past(cmd.rd_cur), "shift write without read")

endmodule

`default_nettype wire

/* src/pal_dp.sv */
// Datapath of the positional array list: request, length, shift index,
// element RAM and result register. Depends on pal_pkg, pal_ram and the
// assertion header.
`default_nettype none

module pal_dp #(
  parameter int CAPACITY = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pal_pkg::in_item_t  in_data,
  input  wire pal_pkg::cmd_t      cmd,
  output pal_pkg::stat_t          st,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output pal_pkg::out_item_t      out_data
);

  import pal_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  in_item_t          req_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     idx_nxt;
  status_t           status_r;
  logic [VAL_W-1:0]  rdval_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [POS_W-1:0]  pos_m1;
  logic [AW-1:0]     p0;
  logic [CW-1:0]     idx_m1;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     cnt_ext;
  logic              pos_zero;
  logic              full;
  status_t           err_code;

  logic              ram_we;
  logic [AW-1:0]     ram_wa;
  logic [VAL_W-1:0]  ram_wd;
  logic              ram_re;
  logic [AW-1:0]     ram_ra;
  logic [VAL_W-1:0]  ram_rd;

  // Position and index arithmetic
  assign pos_m1   = req_r.position - POS_W'(1);
  assign p0       = AW'(pos_m1);
  assign idx_m1   = idx_r - CW'(1);
  assign pos_ext  = PW'(req_r.position);
  assign cnt_ext  = PW'(count_r);
  assign pos_zero = (req_r.position == '0);
  assign full     = (count_r == CW'(CAPACITY));

  // Classify the request
  always_comb begin
    case (req_r.action)
      ACT_GET, ACT_DELETE: begin
        err_code = (pos_zero || (pos_ext > cnt_ext)) ? ST_BAD_POS : ST_OK;
      end
      ACT_INSERT: begin
        if (full) begin
          err_code = ST_FULL;
        end else if (pos_zero || (pos_ext > (cnt_ext + PW'(1)))) begin
          err_code = ST_BAD_POS;
        end else begin
          err_code = ST_OK;
        end
      end
      default: begin
        err_code = (count_r == '0) ? ST_EMPTY : ST_OK;
      end
    endcase
  end

  assign st.action   = req_r.action;
  assign st.err      = (err_code != ST_OK);
  assign st.ins_more = (idx_r > CW'(p0));
  assign st.del_more = (idx_r < count_r);
  assign st.out_busy = out_valid_r && out_stall;

  // RAM port selection
  always_comb begin
    ram_re = cmd.rd_p0 || cmd.rd_prev || cmd.rd_cur;
    if (cmd.rd_p0) begin
      ram_ra = p0;
    end else if (cmd.rd_prev) begin
      ram_ra = idx_m1[AW-1:0];
    end else begin
      ram_ra = idx_r[AW-1:0];
    end
    ram_we = cmd.shift_up || cmd.shift_dn || cmd.put_val;
    if (cmd.put_val) begin
      ram_wa = p0;
      ram_wd = req_r.value;
    end else if (cmd.shift_dn) begin
      ram_wa = idx_m1[AW-1:0];
      ram_wd = ram_rd;
    end else begin
      ram_wa = idx_r[AW-1:0];
      ram_wd = ram_rd;
    end
  end

  pal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // Length and shift index updates
  always_comb begin
    count_nxt = count_r;
    if (cmd.decode && (req_r.action == ACT_CLEAR) && (err_code == ST_OK)) begin
      count_nxt = '0;
    end else if (cmd.put_val) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.dec_cnt) begin
      count_nxt = count_r - CW'(1);
    end
    idx_nxt = idx_r;
    if (cmd.decode) begin
      idx_nxt = (req_r.action == ACT_INSERT) ? count_r : (CW'(p0) + CW'(1));
    end else if (cmd.shift_up) begin
      idx_nxt = idx_m1;
    end else if (cmd.shift_dn) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.ld_req) begin
      req_r <= in_data;
    end
    if (cmd.decode) begin
      status_r <= err_code;
      rdval_r  <= '0;
    end else if (cmd.cap_rd) begin
      rdval_r <= ram_rd;
    end
    if (cmd.ld_out) begin
      out_data_r.status         <= status_r;
      out_data_r.read_value     <= rdval_r;
      out_data_r.current_length <= LEN_W'(count_r);
      out_data_r.is_empty       <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "positional_array_list_assert.svh"

  `PAL_ASSERT(a_count_cap, count_r <= CW'(CAPACITY), "length above capacity")
  `PAL_ASSERT_ALWAYS(a_one_writer, $onehot0({cmd.shift_up, cmd.shift_dn, cmd.put_val}), "RAM write conflict")
  `PAL_ASSERT(a_put_room, cmd.put_val |-> (count_r < CW'(CAPACITY)), "insert into full list")

endmodule

`default_nettype wire

/* src/positional_array_list.sv */
// Positional array list: an ordered list of up to CAPACITY signed 32-bit
// values held in a single-port-write RAM, addressed by 1-based position. One
// request (get, insert, delete, clear) is taken at a time and gives exactly
// one result beat with status, value, length and empty flag. Shifting
// dominates: each moved element costs one RAM read and one RAM write. A
// finished result waits in the output register while the next request is
// worked on. No clearing pass after reset.
// Depends on pal_pkg, pal_ctrl, pal_dp and pal_ram.
`default_nettype none

module positional_array_list #(
  parameter int CAPACITY = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pal_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pal_pkg::out_item_t      out_data
);

  import pal_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // Sequencer
  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Storage and result path
  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
